// ===== rtl/core/cbse_pkg.sv =====
// ---------------------------------------------------------------------------
// cbse_pkg : shared types and constants of the B-spline segment evaluator
// Payload structs, configuration layout, stage latencies and the reciprocal
// constant used for the divide-by-six in the position weights.
// ---------------------------------------------------------------------------
`default_nettype none

package cbse_pkg;

    // Q16.16 signed coordinate
    typedef logic signed [31:0] coord_t;

    // four control points, one coordinate axis per member
    typedef struct packed {
        coord_t [3:0] x;
        coord_t [3:0] y;
    } points_t;

    // basis weights in Q2.30: position, first and second derivative
    typedef struct packed {
        coord_t [3:0] wp;
        coord_t [3:0] wv;
        coord_t [3:0] wa;
    } weights_t;

    // position and derivatives, saturated Q16.16
    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t vel_x;
        coord_t vel_y;
        coord_t acc_x;
        coord_t acc_y;
    } motion_t;

    // configuration register set
    typedef struct packed {
        logic [31:0] desired_speed;
        logic [31:0] curvature_gain;
        logic [31:0] norm_offset;
    } cfg_t;

    typedef enum logic [1:0] {
        CFG_DESIRED_SPEED  = 2'd0,
        CFG_CURVATURE_GAIN = 2'd1,
        CFG_NORM_OFFSET    = 2'd2
    } cfg_index_t;

    localparam logic [31:0] DESIRED_SPEED_RESET = 32'd65536;

    // stage counts of each unit
    localparam int LAT_WEIGHTS = 5;
    localparam int LAT_COMBINE = 3;
    localparam int SQRT_STAGES = 16;
    localparam int LAT_NORM    = SQRT_STAGES + 2;
    localparam int DIV_STAGES  = 16;
    localparam int LAT_PROFILE = DIV_STAGES + 6;

    // floor(x / 6) = (x * RECIP_SIX) >> RECIP_SHIFT, exact for x < 2^33
    localparam logic [32:0] RECIP_SIX   = 33'd5726623062;
    localparam int          RECIP_SHIFT = 35;

endpackage

`default_nettype wire

// ===== rtl/core/cbse_weights.sv =====
// ---------------------------------------------------------------------------
// cbse_weights : basis weight pipeline
// Five stages from the curve parameter to the twelve Q2.30 basis weights.
// The control points travel alongside so they leave with their weights.
// ---------------------------------------------------------------------------
`default_nettype none

module cbse_weights (
    input  logic               clk,
    input  logic               adv,
    input  logic [15:0]        curve_param,
    input  cbse_pkg::points_t  pts_in,
    output cbse_pkg::weights_t w_out,
    output cbse_pkg::points_t  pts_out
);

    // stage 1: u, s = 1 - u and their squares
    logic [15:0] u1_reg;
    logic [16:0] s1_reg;
    logic [31:0] u2_1_reg;
    logic [32:0] s2_1_reg;
    logic [16:0] s_in;

    // stage 2: cubes, derivative weights
    logic [15:0] u_2_reg;
    logic [31:0] u2_2_reg;
    logic [47:0] u3_2_reg;
    logic [49:0] s3_2_reg;
    cbse_pkg::weights_t w2_reg;

    // stage 3: rounded, pre-shifted numerators
    logic [32:0] x3_reg [4];
    cbse_pkg::weights_t w3_reg;

    // stage 4: reciprocal products
    logic [65:0] prod4_reg [4];
    cbse_pkg::weights_t w4_reg;

    // stage 5: output
    cbse_pkg::weights_t w5_reg;
    cbse_pkg::points_t  pts_reg [cbse_pkg::LAT_WEIGHTS];

    // derivative weight arithmetic
    logic signed [35:0] su, ss, su2;
    logic signed [35:0] wv_n [4];
    logic signed [35:0] wa_n [4];

    // numerator arithmetic
    logic signed [52:0] su3, su2b, sub, ss3;
    logic signed [52:0] num [4];

    assign s_in = 17'(17'd65536 - {1'b0, curve_param});

    always_comb
    begin
        su  = $signed({20'b0, u1_reg});
        ss  = $signed({19'b0, s1_reg});
        su2 = $signed({4'b0, u2_1_reg});
        // round half up of n / 8
        wv_n[0] = 36'sd4 - $signed({3'b0, s2_1_reg});
        wv_n[1] = 36'sd3 * su2 - (su <<< 18) + 36'sd4;
        wv_n[2] = -(36'sd3 * su2) + (su <<< 17) + 36'sd4294967300;
        wv_n[3] = su2 + 36'sd4;
        // second derivative weights, exact
        wa_n[0] = ss <<< 14;
        wa_n[1] = (36'sd3 * su - 36'sd131072) <<< 14;
        wa_n[2] = (36'sd65536 - 36'sd3 * su) <<< 14;
        wa_n[3] = su <<< 14;
    end

    always_comb
    begin
        su3  = $signed({5'b0, u3_2_reg});
        ss3  = $signed({3'b0, s3_2_reg});
        su2b = $signed({21'b0, u2_2_reg});
        sub  = $signed({37'b0, u_2_reg});
        // numerators over 6 * 2^48
        num[0] = ss3;
        num[1] = 53'sd3 * su3 - ((53'sd6 * su2b) <<< 16) + (53'sd1 <<< 50);
        num[2] = -(53'sd3 * su3) + ((53'sd3 * su2b) <<< 16) + ((53'sd3 * sub) <<< 32)
                 + (53'sd1 <<< 48);
        num[3] = su3;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u1_reg   <= curve_param;
            s1_reg   <= s_in;
            u2_1_reg <= 32'({16'b0, curve_param} * {16'b0, curve_param});
            s2_1_reg <= 33'({16'b0, s_in} * {16'b0, s_in});

            u_2_reg  <= u1_reg;
            u2_2_reg <= u2_1_reg;
            u3_2_reg <= 48'(u2_1_reg) * 48'(u1_reg);
            s3_2_reg <= 50'(s2_1_reg) * 50'(s1_reg);
            for (int i = 0; i < 4; i++)
            begin
                w2_reg.wp[i] <= '0;
                w2_reg.wv[i] <= 32'(wv_n[i] >>> 3);
                w2_reg.wa[i] <= 32'(wa_n[i]);
            end

            for (int i = 0; i < 4; i++)
            begin
                x3_reg[i] <= 33'((num[i] + 53'sd786432) >>> 18);
            end
            w3_reg <= w2_reg;

            for (int i = 0; i < 4; i++)
            begin
                prod4_reg[i] <= 66'(x3_reg[i]) * 66'(cbse_pkg::RECIP_SIX);
            end
            w4_reg <= w3_reg;

            w5_reg.wv <= w4_reg.wv;
            w5_reg.wa <= w4_reg.wa;
            for (int i = 0; i < 4; i++)
            begin
                w5_reg.wp[i] <= 32'(prod4_reg[i] >> cbse_pkg::RECIP_SHIFT);
            end

            // points ride along
            pts_reg[0] <= pts_in;
            for (int k = 1; k < cbse_pkg::LAT_WEIGHTS; k++)
            begin
                pts_reg[k] <= pts_reg[k - 1];
            end
        end
    end

    assign w_out   = w5_reg;
    assign pts_out = pts_reg[cbse_pkg::LAT_WEIGHTS - 1];

endmodule

`default_nettype wire

// ===== rtl/core/cbse_combine.sv =====
// ---------------------------------------------------------------------------
// cbse_combine : weighted point sums
// Three stages: 24 products, six four-term sums, round half up to Q16.16
// with saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module cbse_combine (
    input  logic               clk,
    input  logic               adv,
    input  cbse_pkg::weights_t w_in,
    input  cbse_pkg::points_t  pts_in,
    output cbse_pkg::motion_t  m_out
);

    logic signed [63:0] prod_reg [3][2][4];
    logic signed [65:0] sum_reg  [3][2];
    cbse_pkg::motion_t  m_reg;

    cbse_pkg::coord_t wset [3][4];
    cbse_pkg::coord_t pset [2][4];

    // Q2.30 x Q16.16 -> Q16.16, round half up, saturate
    function automatic cbse_pkg::coord_t round_sat(input logic signed [65:0] s);
        logic signed [65:0] t;
        cbse_pkg::coord_t   r;
        t = (s + 66'sd536870912) >>> 30;
        if (t > 66'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (t < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = 32'(t);
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            wset[0][i] = w_in.wp[i];
            wset[1][i] = w_in.wv[i];
            wset[2][i] = w_in.wa[i];
            pset[0][i] = pts_in.x[i];
            pset[1][i] = pts_in.y[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // products
            for (int j = 0; j < 3; j++)
                for (int a = 0; a < 2; a++)
                    for (int i = 0; i < 4; i++)
                        prod_reg[j][a][i] <= 64'(wset[j][i]) * 64'(pset[a][i]);
            // sums
            for (int j = 0; j < 3; j++)
                for (int a = 0; a < 2; a++)
                    sum_reg[j][a] <= 66'(prod_reg[j][a][0]) + 66'(prod_reg[j][a][1])
                                   + 66'(prod_reg[j][a][2]) + 66'(prod_reg[j][a][3]);
            // rounding
            m_reg.pos_x <= round_sat(sum_reg[0][0]);
            m_reg.pos_y <= round_sat(sum_reg[0][1]);
            m_reg.vel_x <= round_sat(sum_reg[1][0]);
            m_reg.vel_y <= round_sat(sum_reg[1][1]);
            m_reg.acc_x <= round_sat(sum_reg[2][0]);
            m_reg.acc_y <= round_sat(sum_reg[2][1]);
        end
    end

    assign m_out = m_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cbse_isqrt.sv =====
// ---------------------------------------------------------------------------
// cbse_isqrt : pipelined Euclidean norm
// floor(sqrt(a^2 + b^2)): squares, sum, then a restoring square root that
// settles two result bits per stage over sixteen stages.
// ---------------------------------------------------------------------------
`default_nettype none

module cbse_isqrt (
    input  logic             clk,
    input  logic             adv,
    input  cbse_pkg::coord_t a,
    input  cbse_pkg::coord_t b,
    output logic [31:0]      root
);

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sq_state_t;

    logic [63:0] sqa_reg, sqb_reg, rad_reg;
    sq_state_t   sq_reg  [cbse_pkg::SQRT_STAGES];
    sq_state_t   sq_next [cbse_pkg::SQRT_STAGES];
    sq_state_t   sq_first;

    // two digit steps of the restoring square root
    function automatic sq_state_t sq_two(input sq_state_t s_in);
        sq_state_t   s;
        logic [33:0] cur;
        logic [33:0] trial;
        s = s_in;
        for (int k = 0; k < 2; k++)
        begin
            cur   = {s.rem[31:0], s.rad[63:62]};
            s.rad = {s.rad[61:0], 2'b00};
            trial = {s.root, 2'b01};
            if (cur >= trial)
            begin
                s.rem  = cur - trial;
                s.root = {s.root[30:0], 1'b1};
            end
            else
            begin
                s.rem  = cur;
                s.root = {s.root[30:0], 1'b0};
            end
        end
        return s;
    endfunction

    assign sq_first = '{rad: rad_reg, rem: '0, root: '0};

    always_comb
    begin
        sq_next[0] = sq_two(sq_first);
        for (int k = 1; k < cbse_pkg::SQRT_STAGES; k++)
            sq_next[k] = sq_two(sq_reg[k - 1]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqa_reg <= $unsigned(64'(a) * 64'(a));
            sqb_reg <= $unsigned(64'(b) * 64'(b));
            rad_reg <= sqa_reg + sqb_reg;
            for (int k = 0; k < cbse_pkg::SQRT_STAGES; k++)
                sq_reg[k] <= sq_next[k];
        end
    end

    assign root = sq_reg[cbse_pkg::SQRT_STAGES - 1].root;

endmodule

`default_nettype wire

// ===== rtl/core/cbse_profile.sv =====
// ---------------------------------------------------------------------------
// cbse_profile : speed profile pipeline
// Offsets the norms, forms the curvature factor and the divisor
// vel_norm * factor, then divides desired_speed * 2^32 by it with a
// restoring divider, two quotient bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module cbse_profile (
    input  logic           clk,
    input  logic           adv,
    input  cbse_pkg::cfg_t cfg,
    input  logic [31:0]    vel_root,
    input  logic [31:0]    acc_root,
    output logic [31:0]    quot,
    output logic           sat,
    output logic           big,
    output logic           zdiv
);

    typedef struct packed {
        logic [64:0] rem;
        logic [63:0] dv;
        logic [31:0] q;
        logic        sat;
        logic        big;
        logic        zd;
    } div_state_t;

    logic [32:0] vn1_reg, an1_reg;
    logic        zd1_reg, zd2_reg, zd3_reg, zd4_reg, zd5_reg;
    logic [32:0] vn2_reg, vn3_reg;
    logic [48:0] gh2_reg;
    logic [47:0] gl2_reg;
    logic [49:0] fac3_reg;
    logic [57:0] dl4_reg, dh4_reg;
    logic [82:0] d5_reg;
    logic [32:0] vn_sum;

    div_state_t div_first_reg;
    div_state_t div_reg  [cbse_pkg::DIV_STAGES];
    div_state_t div_next [cbse_pkg::DIV_STAGES];

    // two steps of the restoring divider; low dividend bits are zero
    function automatic div_state_t div_two(input div_state_t s_in);
        div_state_t  s;
        logic [64:0] cur;
        s = s_in;
        for (int k = 0; k < 2; k++)
        begin
            cur = {s.rem[63:0], 1'b0};
            if (cur >= {1'b0, s.dv})
            begin
                s.rem = cur - {1'b0, s.dv};
                s.q   = {s.q[30:0], 1'b1};
            end
            else
            begin
                s.rem = cur;
                s.q   = {s.q[30:0], 1'b0};
            end
        end
        return s;
    endfunction

    assign vn_sum = 33'(cfg.norm_offset) + 33'(vel_root);

    always_comb
    begin
        div_next[0] = div_two(div_first_reg);
        for (int k = 1; k < cbse_pkg::DIV_STAGES; k++)
            div_next[k] = div_two(div_reg[k - 1]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // offset norms
            vn1_reg <= vn_sum;
            an1_reg <= 33'(cfg.norm_offset) + 33'(acc_root);
            zd1_reg <= (vn_sum == 33'd0);

            // gain products
            gh2_reg <= 49'(cfg.curvature_gain) * 49'(an1_reg[32:16]);
            gl2_reg <= 48'(cfg.curvature_gain) * 48'(an1_reg[15:0]);
            vn2_reg <= vn1_reg;
            zd2_reg <= zd1_reg;

            // curvature factor
            fac3_reg <= 50'd65536 + 50'(gh2_reg) + 50'(gl2_reg[47:16]);
            vn3_reg  <= vn2_reg;
            zd3_reg  <= zd2_reg;

            // divisor partial products
            dl4_reg <= 58'(vn3_reg) * 58'(fac3_reg[24:0]);
            dh4_reg <= 58'(vn3_reg) * 58'(fac3_reg[49:25]);
            zd4_reg <= zd3_reg;

            d5_reg  <= 83'(dl4_reg) + (83'(dh4_reg) << 25);
            zd5_reg <= zd4_reg;

            // divider set-up: overflow and oversized divisor checks
            div_first_reg.rem <= 65'(cfg.desired_speed);
            div_first_reg.dv  <= d5_reg[63:0];
            div_first_reg.q   <= '0;
            div_first_reg.sat <= (83'(cfg.desired_speed) >= d5_reg);
            div_first_reg.big <= |d5_reg[82:64];
            div_first_reg.zd  <= zd5_reg;

            for (int k = 0; k < cbse_pkg::DIV_STAGES; k++)
                div_reg[k] <= div_next[k];
        end
    end

    assign quot = div_reg[cbse_pkg::DIV_STAGES - 1].q;
    assign sat  = div_reg[cbse_pkg::DIV_STAGES - 1].sat;
    assign big  = div_reg[cbse_pkg::DIV_STAGES - 1].big;
    assign zdiv = div_reg[cbse_pkg::DIV_STAGES - 1].zd;

endmodule

`default_nettype wire

// ===== rtl/core/cubic_bspline_reference_evaluator.sv =====
// ---------------------------------------------------------------------------
// cubic_bspline_reference_evaluator : uniform cubic B-spline segment evaluator
// Position, first and second derivative of one segment from four control
// points, plus the speed profile for a target path speed.
// ---------------------------------------------------------------------------
//  channel   signals                          direction  accepted when
//  input     in_valid/in_stall, points, t     in         in_valid && !in_stall
//  output    out_valid/out_stall, results     out        out_valid && !out_stall
//  config    cfg_valid/cfg_ready, index/data  in         cfg_valid && cfg_ready
//
//  One item enters per cycle while in_stall is low. Each item passes through
//  the weights, sums, norm square root, profile divider and output register.
//  The whole pipeline advances together; out_stall on a full output register
//  freezes every stage and raises in_stall in the same cycle.
//  Reset clears the valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module cubic_bspline_reference_evaluator (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] point0_x,
    input  logic [31:0] point0_y,
    input  logic [31:0] point1_x,
    input  logic [31:0] point1_y,
    input  logic [31:0] point2_x,
    input  logic [31:0] point2_y,
    input  logic [31:0] point3_x,
    input  logic [31:0] point3_y,
    input  logic [15:0] curve_param,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [31:0] vel_x,
    output logic [31:0] vel_y,
    output logic [31:0] acc_x,
    output logic [31:0] acc_y,
    output logic [31:0] speed_profile,
    output logic        zero_divide,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int MOT_DELAY  = cbse_pkg::LAT_NORM + cbse_pkg::LAT_PROFILE;
    localparam int PIPE_DEPTH = cbse_pkg::LAT_WEIGHTS + cbse_pkg::LAT_COMBINE
                              + MOT_DELAY + 1;

    logic                   adv;
    logic [PIPE_DEPTH-1:0]  valid_reg;
    cbse_pkg::cfg_t         cfg_reg;
    cbse_pkg::points_t      pts_in, pts_w;
    cbse_pkg::weights_t     weights;
    cbse_pkg::motion_t      motion;
    cbse_pkg::motion_t      mot_dly_reg [MOT_DELAY];
    cbse_pkg::motion_t      out_mot_reg;
    logic [31:0]            vel_root, acc_root, quot;
    logic                   prof_sat, prof_big, prof_zd;
    logic [31:0]            speed_reg;
    logic                   zdiv_reg;

    // pipeline advance
    assign adv       = !valid_reg[PIPE_DEPTH-1] || !out_stall;
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.desired_speed  <= cbse_pkg::DESIRED_SPEED_RESET;
            cfg_reg.curvature_gain <= '0;
            cfg_reg.norm_offset    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cbse_pkg::cfg_index_t'(cfg_index))
                cbse_pkg::CFG_DESIRED_SPEED:  cfg_reg.desired_speed  <= cfg_data;
                cbse_pkg::CFG_CURVATURE_GAIN: cfg_reg.curvature_gain <= cfg_data;
                cbse_pkg::CFG_NORM_OFFSET:    cfg_reg.norm_offset    <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits, one per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], in_valid};
    end

    always_comb
    begin
        pts_in.x[0] = point0_x;
        pts_in.y[0] = point0_y;
        pts_in.x[1] = point1_x;
        pts_in.y[1] = point1_y;
        pts_in.x[2] = point2_x;
        pts_in.y[2] = point2_y;
        pts_in.x[3] = point3_x;
        pts_in.y[3] = point3_y;
    end

    cbse_weights u_weights (
        .clk         (clk),
        .adv         (adv),
        .curve_param (curve_param),
        .pts_in      (pts_in),
        .w_out       (weights),
        .pts_out     (pts_w)
    );

    cbse_combine u_combine (
        .clk    (clk),
        .adv    (adv),
        .w_in   (weights),
        .pts_in (pts_w),
        .m_out  (motion)
    );

    cbse_isqrt u_vel_norm (
        .clk  (clk),
        .adv  (adv),
        .a    (motion.vel_x),
        .b    (motion.vel_y),
        .root (vel_root)
    );

    cbse_isqrt u_acc_norm (
        .clk  (clk),
        .adv  (adv),
        .a    (motion.acc_x),
        .b    (motion.acc_y),
        .root (acc_root)
    );

    cbse_profile u_profile (
        .clk      (clk),
        .adv      (adv),
        .cfg      (cfg_reg),
        .vel_root (vel_root),
        .acc_root (acc_root),
        .quot     (quot),
        .sat      (prof_sat),
        .big      (prof_big),
        .zdiv     (prof_zd)
    );

    // motion delay line and output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mot_dly_reg[0] <= motion;
            for (int k = 1; k < MOT_DELAY; k++)
                mot_dly_reg[k] <= mot_dly_reg[k - 1];
            out_mot_reg <= mot_dly_reg[MOT_DELAY - 1];
            if (prof_sat)
                speed_reg <= 32'hFFFFFFFF;
            else if (prof_big)
                speed_reg <= '0;
            else
                speed_reg <= quot;
            zdiv_reg <= prof_zd;
        end
    end

    assign out_valid     = valid_reg[PIPE_DEPTH-1];
    assign pos_x         = out_mot_reg.pos_x;
    assign pos_y         = out_mot_reg.pos_y;
    assign vel_x         = out_mot_reg.vel_x;
    assign vel_y         = out_mot_reg.vel_y;
    assign acc_x         = out_mot_reg.acc_x;
    assign acc_y         = out_mot_reg.acc_y;
    assign speed_profile = speed_reg;
    assign zero_divide   = zdiv_reg;

    // checks
    a_zero_div_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_divide) |-> (speed_profile == 32'hFFFFFFFF))
        else $error("zero_divide without saturated profile");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted item missing from first stage");

    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> (valid_reg == $past(valid_reg)))
        else $error("pipeline moved while frozen");

endmodule

`default_nettype wire

// ===== verif/tb_cubic_bspline_reference_evaluator.sv =====
// ---------------------------------------------------------------------------
// tb_cubic_bspline_reference_evaluator : self-checking bench of the evaluator
// Drives control point sets and curve parameters in bursts against a stalling
// receiver, predicts position, derivatives and speed profile with a bit-exact
// fixed-point model, and checks every result item in order. The registers
// move through several settings, the extremes among them, between drained
// phases.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_cubic_bspline_reference_evaluator;

    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int         PIPE_DEPTH      = 49;

    typedef struct {
        logic [31:0] px [4];
        logic [31:0] py [4];
        logic [15:0] t;
    } seg_item_t;

    typedef struct {
        logic [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
        logic [31:0] speed;
        logic        zdiv;
    } motion_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] point0_x, point0_y, point1_x, point1_y;
    logic [31:0] point2_x, point2_y, point3_x, point3_y;
    logic [15:0] curve_param;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
    logic [31:0] speed_profile;
    logic        zero_divide;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // bench copy of the register set
    logic [31:0] m_speed  = cbse_pkg::DESIRED_SPEED_RESET;
    logic [31:0] m_gain   = 32'd0;
    logic [31:0] m_offset = 32'd0;

    seg_item_t   pending_items [$];
    motion_res_t expected_motion [$];
    int          mismatch_count = 0;

    cubic_bspline_reference_evaluator u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .point0_x(point0_x), .point0_y(point0_y),
        .point1_x(point1_x), .point1_y(point1_y),
        .point2_x(point2_x), .point2_y(point2_y),
        .point3_x(point3_x), .point3_y(point3_y),
        .curve_param(curve_param),
        .out_valid(out_valid), .out_stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
        .acc_x(acc_x), .acc_y(acc_y),
        .speed_profile(speed_profile), .zero_divide(zero_divide),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // fixed-point prediction
    // ------------------------------------------------------------------
    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint round_div(longint n, longint d);
        return floor_div(n + d / 2, d);
    endfunction

    // weighted sum in Q2.30 x Q16.16, rounded half up, saturated
    function automatic logic [31:0] weighted_sum(longint w [4], longint p [4]);
        logic signed [95:0] acc;
        acc = 96'sd0;
        for (int i = 0; i < 4; i++)
            acc += w[i] * p[i];
        acc = (acc + (96'sd1 <<< 29)) >>> 30;
        if (acc > 96'sd2147483647)
            return 32'h7FFF_FFFF;
        if (acc < -96'sd2147483648)
            return 32'h8000_0000;
        return acc[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned vec_norm(logic [31:0] x, logic [31:0] y);
        longint sx, sy;
        sx = longint'($signed(x));
        sy = longint'($signed(y));
        return int_sqrt(longint'(sx * sx) + longint'(sy * sy));
    endfunction

    function automatic motion_res_t predict_motion(seg_item_t it);
        motion_res_t r;
        longint px [4], py [4], wp [4], wv [4], wa [4];
        longint u, s, tt, dpos;
        longint unsigned vn, an, fac, q;
        tt   = 65536;
        dpos = 6 * (longint'(1) << 18);
        u    = longint'(it.t);
        s    = tt - u;
        for (int i = 0; i < 4; i++)
        begin
            px[i] = longint'($signed(it.px[i]));
            py[i] = longint'($signed(it.py[i]));
        end
        wp[0] = round_div(s * s * s, dpos);
        wp[1] = round_div(3 * u * u * u - 6 * u * u * tt + 4 * tt * tt * tt, dpos);
        wp[2] = round_div(-3 * u * u * u + 3 * u * u * tt + 3 * u * tt * tt
                          + tt * tt * tt, dpos);
        wp[3] = round_div(u * u * u, dpos);
        wv[0] = round_div(-(s * s), 8);
        wv[1] = round_div(3 * u * u - 4 * u * tt, 8);
        wv[2] = round_div(-3 * u * u + 2 * u * tt + tt * tt, 8);
        wv[3] = round_div(u * u, 8);
        wa[0] = s * 16384;
        wa[1] = (3 * u - 2 * tt) * 16384;
        wa[2] = (tt - 3 * u) * 16384;
        wa[3] = u * 16384;
        r.pos_x = weighted_sum(wp, px);
        r.pos_y = weighted_sum(wp, py);
        r.vel_x = weighted_sum(wv, px);
        r.vel_y = weighted_sum(wv, py);
        r.acc_x = weighted_sum(wa, px);
        r.acc_y = weighted_sum(wa, py);
        vn  = 64'(m_offset) + vec_norm(r.vel_x, r.vel_y);
        an  = 64'(m_offset) + vec_norm(r.acc_x, r.acc_y);
        fac = 64'd65536 + 64'(m_gain) * (an >> 16)
              + ((64'(m_gain) * (an & 64'hFFFF)) >> 16);
        if (vn == 0)
        begin
            r.speed = 32'hFFFF_FFFF;
            r.zdiv  = 1'b1;
        end
        else
        begin
            q = (64'(m_speed) << 32) / vn;
            q = q / fac;
            r.speed = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            r.zdiv  = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input driver: bursts from the pending queue with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        seg_item_t it;
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (in_valid)
            begin
                it.px = '{point0_x, point1_x, point2_x, point3_x};
                it.py = '{point0_y, point1_y, point2_y, point3_y};
                it.t  = curve_param;
                expected_motion = {expected_motion, predict_motion(it)};
            end
            if (gap_left > 0 || pending_items.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                it = pending_items.pop_front();
                point0_x <= it.px[0]; point0_y <= it.py[0];
                point1_x <= it.px[1]; point1_y <= it.py[1];
                point2_x <= it.px[2]; point2_y <= it.py[2];
                point3_x <= it.px[3]; point3_y <= it.py[3];
                curve_param <= it.t;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(60, 0);
                    gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver stall pattern
    // ------------------------------------------------------------------
    int stall_mode  = 0;
    int stall_timer = 0;

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        motion_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_motion.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item, pos_x %h", pos_x);
            end
            else
            begin
                e = expected_motion.pop_front();
                check_field("pos_x", e.pos_x, pos_x);
                check_field("pos_y", e.pos_y, pos_y);
                check_field("vel_x", e.vel_x, vel_x);
                check_field("vel_y", e.vel_y, vel_y);
                check_field("acc_x", e.acc_x, acc_x);
                check_field("acc_y", e.acc_y, acc_y);
                check_field("speed_profile", e.speed, speed_profile);
                check_field("zero_divide", 32'(e.zdiv), 32'(zero_divide));
            end
        end
        // switch stall behaviour every so often
        if (stall_timer == 0)
        begin
            stall_mode  = $urandom_range(3, 0);
            stall_timer = $urandom_range(300, 20);
        end
        else
            stall_timer--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(9, 0) < 3);
            2: out_stall <= (stall_timer % 5 < 2);
            default: out_stall <= ($urandom_range(9, 0) < 8);
        endcase
    end

    // ------------------------------------------------------------------
    // stimulus sequencing
    // ------------------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            cbse_pkg::CFG_DESIRED_SPEED:  m_speed  = data;
            cbse_pkg::CFG_CURVATURE_GAIN: m_gain   = data;
            cbse_pkg::CFG_NORM_OFFSET:    m_offset = data;
            default: ;
        endcase
    endtask

    task automatic drain;
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_motion.size() != 0);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
    endtask

    task automatic push_uniform(logic [31:0] v, logic [15:0] t);
        seg_item_t it;
        it.px = '{v, v, v, v};
        it.py = '{v, v, v, v};
        it.t  = t;
        pending_items = {pending_items, it};
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4, 0))
            0: return $urandom_range(1 << 20, 0) - (1 << 19);
            1: return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_random(int count);
        seg_item_t it;
        logic [31:0] v;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                it.px[i] = rand_coord();
                it.py[i] = rand_coord();
            end
            // equal points now and then give a stationary segment
            if ($urandom_range(15, 0) == 0)
            begin
                v = rand_coord();
                it.px = '{v, v, v, v};
                v = rand_coord();
                it.py = '{v, v, v, v};
            end
            case ($urandom_range(7, 0))
                0: it.t = 16'h0000;
                1: it.t = 16'hFFFF;
                default: it.t = $urandom;
            endcase
            pending_items = {pending_items, it};
        end
    endtask

    task automatic push_directed;
        seg_item_t it;
        push_uniform(32'h0000_0000, 16'h0000);      // stationary, zero norm
        push_uniform(32'h7FFF_FFFF, 16'hFFFF);
        push_uniform(32'h8000_0000, 16'h8000);
        it.px = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        it.py = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        it.t  = 16'h0000;
        pending_items = {pending_items, it};
        it.t  = 16'hFFFF;
        pending_items = {pending_items, it};
        it.t  = 16'h5555;
        pending_items = {pending_items, it};
        it.px = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA};
        it.py = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
        it.t  = 16'hAAAA;
        pending_items = {pending_items, it};
        // straight line at unit spacing
        it.px = '{32'h0000_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000};
        it.py = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
        it.t  = 16'h0001;
        pending_items = {pending_items, it};
        it.t  = 16'h8000;
        pending_items = {pending_items, it};
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = cbse_pkg::CFG_DESIRED_SPEED;
        cfg_data    = 32'd0;
        point0_x = 0; point0_y = 0; point1_x = 0; point1_y = 0;
        point2_x = 0; point2_y = 0; point3_x = 0; point3_y = 0;
        curve_param = 16'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // defaults out of reset
        push_directed();
        push_random(200);
        drain();

        // fastest profile, heaviest curvature slowdown
        write_reg(cbse_pkg::CFG_DESIRED_SPEED, 32'hFFFF_FFFF);
        write_reg(cbse_pkg::CFG_CURVATURE_GAIN, 32'hFFFF_FFFF);
        push_directed();
        push_random(200);
        drain();

        // zero speed, largest offset; spare index must be ignored
        write_reg(cbse_pkg::CFG_DESIRED_SPEED, 32'd0);
        write_reg(cbse_pkg::CFG_CURVATURE_GAIN, 32'd0);
        write_reg(cbse_pkg::CFG_NORM_OFFSET, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_INDEX, 32'h1234_5678);
        push_directed();
        push_random(200);
        drain();

        // smallest nonzero settings
        write_reg(cbse_pkg::CFG_DESIRED_SPEED, 32'd1);
        write_reg(cbse_pkg::CFG_CURVATURE_GAIN, 32'd1);
        write_reg(cbse_pkg::CFG_NORM_OFFSET, 32'd1);
        push_random(200);
        drain();

        // random settings, split by full pauses
        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(cbse_pkg::CFG_DESIRED_SPEED, $urandom);
            write_reg(cbse_pkg::CFG_CURVATURE_GAIN, $urandom_range(1 << 18, 0));
            write_reg(cbse_pkg::CFG_NORM_OFFSET,
                      ph == 0 ? 32'd0 : $urandom_range(1 << 17, 0));
            push_random(80);
            drain();
            push_random(80);
            drain();
        end

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
